/* hw/rtl/taylor_exp_series_unit_macros.svh */
// Assertion helpers shared by the RTL of the exponential series unit.
`ifndef TAYLOR_EXP_SERIES_UNIT_MACROS_SVH
`define TAYLOR_EXP_SERIES_UNIT_MACROS_SVH

// Condition c holds in the same cycle as a.
`define TES_ASSERT_NOW(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("tes assertion failed");

// Condition c holds in the cycle after a.
`define TES_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("tes assertion failed");

`endif

/* hw/rtl/tes_pkg.sv */
`default_nettype none

package tes_pkg;

   localparam int X_W     = 6;
   localparam int THR_W   = 33;
   localparam int MAG_W   = 62;
   localparam int SUM_W   = 63;
   localparam int OUT_W   = 63;
   localparam int TERMS_W = 7;

   localparam logic [MAG_W-1:0] VAL_CAP = {MAG_W{1'b1}};
   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   typedef struct packed {
      logic load;
      logic term_mul;
      logic div_step;
      logic accum;
      logic rcp_init;
      logic rcp_step;
      logic rcp_lead;
   } cmd_type;

   typedef struct packed {
      logic more_terms;
   } status_type;

endpackage

`default_nettype wire

/* hw/rtl/tes_datapath.sv */
`default_nettype none

module tes_datapath #(
   parameter int MAX_TERMS = 96,
   parameter int FRAC_BITS = 32,
   parameter int X_LIMIT   = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [tes_pkg::THR_W-1:0]         csr_write_data,
   input  wire logic signed [tes_pkg::X_W-1:0]    req_x_value,
   input  wire tes_pkg::cmd_type                  cmd,
   output tes_pkg::status_type                    status,
   output logic [tes_pkg::OUT_W-1:0]              rsp_exp_sum,
   output logic [tes_pkg::OUT_W-1:0]              rsp_reciprocal,
   output logic [tes_pkg::TERMS_W-1:0]            rsp_terms_used,
   output logic                                   rsp_saturated
);

   localparam int MAG_W = tes_pkg::MAG_W;
   localparam int SUM_W = tes_pkg::SUM_W;
   localparam int OUT_W = tes_pkg::OUT_W;
   localparam int N_W   = $clog2(MAX_TERMS + 1);
   localparam int AX_W  = $clog2(X_LIMIT + 1);
   localparam int P_W   = MAG_W + AX_W;
   localparam int Q_W   = 2 * FRAC_BITS + 1;
   localparam int CMP_W = (Q_W > OUT_W) ? Q_W : OUT_W;

   logic [tes_pkg::THR_W-1:0] thr_ff, thr_in;
   logic                      neg_ff, neg_in;
   logic [AX_W-1:0]           ax_ff, ax_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [N_W-1:0]            n_ff, n_in;
   logic [N_W-1:0]            rem_ff, rem_in;
   logic                      sat_ff, sat_in;
   logic [MAG_W-1:0]          rr_ff, rr_in;
   logic [Q_W-1:0]            rq_ff, rq_in;

   logic signed [6:0]         x_ext;
   logic signed [6:0]         x_lim;
   logic signed [6:0]         x_abs;
   logic [P_W-1:0]            prod;
   logic                      mul_ovf;
   logic [N_W:0]              div_sh;
   logic                      div_ge;
   logic signed [SUM_W:0]     acc_sum;
   logic signed [SUM_W:0]     acc_cap;
   logic                      term_neg;
   logic                      sum_pos;
   logic [MAG_W-1:0]          divisor;
   logic [MAG_W:0]            rr_sh;
   logic                      rr_ge;
   logic                      mag_above;
   logic [CMP_W-1:0]          rq_wide;
   logic                      rcp_sat;

   always_comb begin
      x_ext = {req_x_value[tes_pkg::X_W-1], req_x_value};
      x_lim = 7'(X_LIMIT);
      x_abs = x_ext[6] ? -x_ext : x_ext;

      prod    = P_W'(mag_ff) * P_W'(ax_ff);
      mul_ovf = prod > P_W'(tes_pkg::VAL_CAP);

      div_sh = {rem_ff, mag_ff[MAG_W-1]};
      div_ge = div_sh >= {1'b0, n_ff};

      term_neg = neg_ff & n_ff[0];
      acc_cap  = signed'((SUM_W + 1)'(tes_pkg::VAL_CAP));
      if (term_neg) begin
         acc_sum = {sum_ff[SUM_W-1], sum_ff} - signed'({2'b00, mag_ff});
      end else begin
         acc_sum = {sum_ff[SUM_W-1], sum_ff} + signed'({2'b00, mag_ff});
      end

      sum_pos = !sum_ff[SUM_W-1] && (sum_ff != '0);
      divisor = sum_pos ? sum_ff[MAG_W-1:0] : '0;
      rr_sh   = {rr_ff, cmd.rcp_lead};
      rr_ge   = rr_sh >= {1'b0, divisor};

      mag_above = {{(MAG_W - tes_pkg::THR_W){1'b0}}, thr_ff} < mag_ff;
      status.more_terms = mag_above && (n_ff < N_W'(MAX_TERMS));
   end

   always_comb begin
      thr_in = thr_ff;
      neg_in = neg_ff;
      ax_in  = ax_ff;
      mag_in = mag_ff;
      sum_in = sum_ff;
      n_in   = n_ff;
      rem_in = rem_ff;
      sat_in = sat_ff;
      rr_in  = rr_ff;
      rq_in  = rq_ff;

      if (csr_write_en) begin
         thr_in = csr_write_data;
      end

      if (cmd.load) begin
         // Out-of-range exponents are clamped silently.
         if (x_ext > x_lim) begin
            neg_in = 1'b0;
            ax_in  = AX_W'(X_LIMIT);
         end else if (x_ext < -x_lim) begin
            neg_in = 1'b1;
            ax_in  = AX_W'(X_LIMIT);
         end else begin
            neg_in = x_ext[6];
            ax_in  = AX_W'(x_abs);
         end
         mag_in = MAG_W'(1) << FRAC_BITS;
         sum_in = SUM_W'(1) << FRAC_BITS;
         n_in   = '0;
         sat_in = 1'b0;
      end

      if (cmd.term_mul) begin
         n_in   = n_ff + N_W'(1);
         rem_in = '0;
         if (mul_ovf) begin
            mag_in = tes_pkg::VAL_CAP;
            sat_in = 1'b1;
         end else begin
            mag_in = prod[MAG_W-1:0];
         end
      end

      // One quotient bit per cycle; the quotient shifts into the term register.
      if (cmd.div_step) begin
         rem_in = div_ge ? N_W'(div_sh - {1'b0, n_ff}) : N_W'(div_sh);
         mag_in = {mag_ff[MAG_W-2:0], div_ge};
      end

      if (cmd.accum) begin
         if (acc_sum > acc_cap) begin
            sum_in = signed'(SUM_W'(acc_cap));
            sat_in = 1'b1;
         end else if (acc_sum < -acc_cap) begin
            sum_in = signed'(SUM_W'(-acc_cap));
            sat_in = 1'b1;
         end else begin
            sum_in = SUM_W'(acc_sum);
         end
      end

      if (cmd.rcp_init) begin
         rr_in = '0;
         rq_in = '0;
         if (mag_above) begin
            sat_in = 1'b1;
         end
      end

      // Restoring division of 2^(2*FRAC_BITS) by the sum: the leading one
      // enters on the first step, zeros after it.
      if (cmd.rcp_step) begin
         rr_in = rr_ge ? MAG_W'(rr_sh - {1'b0, divisor}) : MAG_W'(rr_sh);
         rq_in = {rq_ff[Q_W-2:0], rr_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= tes_pkg::THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      ax_ff  <= ax_in;
      mag_ff <= mag_in;
      sum_ff <= sum_in;
      n_ff   <= n_in;
      rem_ff <= rem_in;
      sat_ff <= sat_in;
      rr_ff  <= rr_in;
      rq_ff  <= rq_in;
   end

   always_comb begin
      rq_wide = CMP_W'(rq_ff);
      rcp_sat = rq_wide > CMP_W'(tes_pkg::OUT_MAX);
      rsp_terms_used = tes_pkg::TERMS_W'(n_ff);
      if (sum_pos) begin
         rsp_exp_sum    = OUT_W'(sum_ff);
         rsp_reciprocal = rcp_sat ? tes_pkg::OUT_MAX : rq_wide[OUT_W-1:0];
         rsp_saturated  = sat_ff | rcp_sat;
      end else begin
         rsp_exp_sum    = '0;
         rsp_reciprocal = tes_pkg::OUT_MAX;
         rsp_saturated  = 1'b1;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/tes_ctrl.sv */
`default_nettype none

`include "taylor_exp_series_unit_macros.svh"

module tes_ctrl #(
   parameter int FRAC_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   output logic                      rsp_valid,
   input  wire tes_pkg::status_type  status,
   output tes_pkg::cmd_type          cmd
);

   localparam int DIV_STEPS = tes_pkg::MAG_W;
   localparam int RCP_STEPS = 2 * FRAC_BITS + 1;
   localparam int CNT_W = $clog2(((RCP_STEPS > DIV_STEPS) ? RCP_STEPS : DIV_STEPS) + 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CHECK = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_ACC   = 7'b0001000,
      ST_RCP   = 7'b0010000,
      ST_DONE  = 7'b0100000,
      ST_SPARE = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cnt_in = '0;
            if (status.more_terms) begin
               cmd.term_mul = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.rcp_init = 1'b1;
               state_in     = ST_RCP;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.accum = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_RCP: begin
            cmd.rcp_step = 1'b1;
            cmd.rcp_lead = (cnt_ff == '0);
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RCP_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   `TES_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid)
   `TES_ASSERT_NEXT(a_start_taken, clock, reset, start && !busy, busy && !rsp_valid)
   `TES_ASSERT_NEXT(a_idle_after_rsp, clock, reset, rsp_valid, !busy)
   `TES_ASSERT_NOW(a_lead_in_rcp, clock, reset, cmd.rcp_lead, cmd.rcp_step)

endmodule

`default_nettype wire

/* hw/rtl/taylor_exp_series_unit.sv */
// Channel    Ports                                     Handshake
// request    start, busy, req_x_value                  taken when start && !busy
// response   rsp_valid, rsp_exp_sum, rsp_reciprocal,   one-cycle strobe, no back-pressure
//            rsp_terms_used, rsp_saturated
// config     csr_write_en, csr_write_data              written when csr_write_en is high
//
// Each request adds T terms (at most MAX_TERMS) to the series; each term passes through
// the multiply, the bit-serial divide by n and the accumulate. The reciprocal divider
// then runs one quotient bit per cycle. busy stays high until the response strobe has
// been shown.
// Reset is synchronous and returns the threshold to 1 and the sequencer to idle.
// The response cannot be stalled; it is valid only during the strobe cycle.
`default_nettype none

module taylor_exp_series_unit #(
   parameter int MAX_TERMS = 96,
   parameter int FRAC_BITS = 32,
   parameter int X_LIMIT   = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [tes_pkg::X_W-1:0]    req_x_value,
   input  wire logic                              csr_write_en,
   input  wire logic [tes_pkg::THR_W-1:0]         csr_write_data,
   output logic                                   rsp_valid,
   output logic [tes_pkg::OUT_W-1:0]              rsp_exp_sum,
   output logic [tes_pkg::OUT_W-1:0]              rsp_reciprocal,
   output logic [tes_pkg::TERMS_W-1:0]            rsp_terms_used,
   output logic                                   rsp_saturated
);

   tes_pkg::cmd_type    cmd;
   tes_pkg::status_type status;

   tes_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   tes_datapath #(
      .MAX_TERMS (MAX_TERMS),
      .FRAC_BITS (FRAC_BITS),
      .X_LIMIT   (X_LIMIT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_x_value    (req_x_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_exp_sum    (rsp_exp_sum),
      .rsp_reciprocal (rsp_reciprocal),
      .rsp_terms_used (rsp_terms_used),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

`default_nettype wire
